// ----- rtl/dflm_pkg.sv -----
// ----------------------------------------------------------------------------
// dflm_pkg
// Shared widths, register map and control types of the dilated FIR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dflm_pkg;

  localparam int MAX_TAPS  = 15;
  localparam int MAX_DIL   = 4;
  localparam int HIST_DEPTH = 64;
  localparam int HIST_AW   = $clog2(HIST_DEPTH);
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int TAP_W     = 4;
  localparam int DIL_W     = 3;
  localparam int SPAN_W    = 6;
  localparam int HALF_W    = 5;
  localparam int POS_W     = 20;   // signed window position
  localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
  localparam int ACC_W     = PROD_W + 4;
  localparam int FRAC_W    = 14;
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;

  // register indexes (paddr[5:3])
  localparam logic [2:0] REG_TAPS   = 3'd0;
  localparam logic [2:0] REG_DIL    = 3'd1;
  localparam logic [2:0] REG_C_LOW  = 3'd2;
  localparam logic [2:0] REG_C_MID  = 3'd3;
  localparam logic [2:0] REG_C_HIGH = 3'd4;
  localparam logic [2:0] REG_C_TOP  = 3'd5;

  typedef logic [MAX_TAPS-1:0][COEF_W-1:0] coef_arr_t;

  typedef struct packed {
    logic [TAP_W-1:0] taps;
    logic [DIL_W-1:0] dil;
    coef_arr_t        coef;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic tap_start;
    logic issue;
    logic load_out;
    logic next_i;
  } cmd_t;

  typedef struct packed {
    logic             emit;
    logic             short_l;
    logic             more;
    logic             pipe_busy;
    logic             out_free;
    logic [TAP_W-1:0] taps;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/dflm_ram.sv -----
// ----------------------------------------------------------------------------
// dflm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dflm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/dflm_regs.sv -----
// ----------------------------------------------------------------------------
// dflm_regs
// APB register file: tap count, dilation and packed coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dflm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [dflm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [dflm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [dflm_pkg::CFG_DW-1:0]  cfg_prdata,
  output dflm_pkg::cfg_t                    cfg
);

  logic [dflm_pkg::TAP_W-1:0] taps_r;
  logic [dflm_pkg::DIL_W-1:0] dil_r;
  logic [63:0] c_low_r, c_mid_r, c_high_r;
  logic [47:0] c_top_r;
  logic        wr;
  logic [2:0]  idx;

  assign wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r   <= 4'd3;
      dil_r    <= 3'd1;
      c_low_r  <= '0;
      c_mid_r  <= '0;
      c_high_r <= '0;
      c_top_r  <= '0;
    end else if (wr) begin
      case (idx)
        dflm_pkg::REG_TAPS:   taps_r   <= cfg_pwdata[3:0];
        dflm_pkg::REG_DIL:    dil_r    <= cfg_pwdata[2:0];
        dflm_pkg::REG_C_LOW:  c_low_r  <= cfg_pwdata;
        dflm_pkg::REG_C_MID:  c_mid_r  <= cfg_pwdata;
        dflm_pkg::REG_C_HIGH: c_high_r <= cfg_pwdata;
        dflm_pkg::REG_C_TOP:  c_top_r  <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dflm_pkg::REG_TAPS:   cfg_prdata = {60'd0, taps_r};
      dflm_pkg::REG_DIL:    cfg_prdata = {61'd0, dil_r};
      dflm_pkg::REG_C_LOW:  cfg_prdata = c_low_r;
      dflm_pkg::REG_C_MID:  cfg_prdata = c_mid_r;
      dflm_pkg::REG_C_HIGH: cfg_prdata = c_high_r;
      dflm_pkg::REG_C_TOP:  cfg_prdata = {16'd0, c_top_r};
      default:              cfg_prdata = '0;
    endcase
  end

  assign cfg.taps = taps_r;
  assign cfg.dil  = dil_r;
  assign cfg.coef = {c_top_r, c_high_r, c_mid_r, c_low_r};

endmodule
`default_nettype wire

// ----- rtl/dflm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dflm_ctrl
// Sequencer: accepts a sample, steps the tap loop and hands out each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dflm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  dflm_pkg::sts_t     sts,
  output dflm_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_TAP, S_WAIT, S_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [dflm_pkg::TAP_W-1:0] j_r, j_nxt;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        if (!sts.emit) begin
          state_nxt = S_IDLE;
        end else if (sts.short_l) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.tap_start = 1'b1;
          j_nxt         = '0;
          state_nxt     = S_TAP;
        end
      end
      S_TAP: begin
        cmd.issue = 1'b1;
        j_nxt     = j_r + 4'd1;
        if (j_r == sts.taps - 4'd1) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.more) begin
            cmd.next_i = 1'b1;
            state_nxt  = S_START;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dflm_dp.sv -----
// ----------------------------------------------------------------------------
// dflm_dp
// Datapath: history RAM, mirrored addressing, tap MAC, rounding and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dflm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  dflm_pkg::cfg_t                     cfg,
  input  dflm_pkg::cmd_t                     cmd,
  output dflm_pkg::sts_t                     sts,
  input  wire logic [dflm_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          in_end,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [dflm_pkg::SAMPLE_W-1:0] out_filtered,
  output logic      [1:0]                    out_flags,
  output logic                               out_last
);

  localparam int PW = dflm_pkg::POS_W;

  // effective configuration for the incoming sample
  logic [dflm_pkg::TAP_W-1:0]  taps_e;
  logic [dflm_pkg::DIL_W-1:0]  dil_e;
  logic [6:0]                  sprod;
  logic [dflm_pkg::SPAN_W-1:0] span_e;
  logic [dflm_pkg::HALF_W-1:0] half_e, hi_e;

  logic [15:0]                 seen_r, p_r, i_r;
  logic                        end_r, emit_r, short_r;
  logic [dflm_pkg::TAP_W-1:0]  taps_r;
  logic [dflm_pkg::DIL_W-1:0]  dil_r;
  logic [dflm_pkg::HALF_W-1:0] half_r;
  logic signed [PW-1:0]        q_r, idx0, idx1, idx2, len;
  logic [dflm_pkg::HIST_AW-1:0] raddr;
  logic [dflm_pkg::SAMPLE_W-1:0] rdata;
  logic                        rd_v_r, prod_v_r;
  logic [dflm_pkg::TAP_W-1:0]  j_d_r;
  logic signed [dflm_pkg::PROD_W-1:0] prod_r;
  logic signed [dflm_pkg::ACC_W-1:0]  acc_r, rnd;
  logic [dflm_pkg::ACC_W-dflm_pkg::FRAC_W-1:0] shr;
  logic                        last_now;

  assign taps_e = (cfg.taps == 4'd0) ? 4'd1 : cfg.taps;
  assign dil_e  = (cfg.dil == 3'd0) ? 3'd1 :
                  (cfg.dil > 3'(dflm_pkg::MAX_DIL)) ? 3'(dflm_pkg::MAX_DIL) : cfg.dil;
  assign sprod  = {3'd0, taps_e - 4'd1} * {4'd0, dil_e};
  assign span_e = sprod[5:0] + 6'd1;
  assign half_e = span_e[5:1];
  assign hi_e   = 5'(span_e - 6'd1 - {1'b0, half_e});

  // mirrored read position
  assign len  = PW'({1'b0, p_r}) + PW'(1);
  assign idx0 = q_r[PW-1] ? ~q_r : q_r;
  assign idx1 = (end_r && idx0 >= len) ? (len + len - PW'(1) - idx0) : idx0;
  assign idx2 = idx1[PW-1] ? '0 : idx1;
  assign raddr = idx2[dflm_pkg::HIST_AW-1:0];

  dflm_ram #(.WIDTH(dflm_pkg::SAMPLE_W), .DEPTH(dflm_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (seen_r[dflm_pkg::HIST_AW-1:0]),
    .wdata (in_sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign last_now = end_r && (i_r == p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        seen_r <= in_end ? 16'd0 : seen_r + 16'd1;
      end
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r     <= seen_r;
      end_r   <= in_end;
      taps_r  <= taps_e;
      dil_r   <= dil_e;
      half_r  <= half_e;
      emit_r  <= in_end || (seen_r >= {11'd0, hi_e});
      short_r <= in_end && ({1'b0, seen_r} + 17'd1 < {11'd0, span_e});
      i_r     <= (seen_r >= {11'd0, hi_e}) ? seen_r - {11'd0, hi_e} : 16'd0;
    end else if (cmd.next_i) begin
      i_r <= i_r + 16'd1;
    end
    if (cmd.tap_start) begin
      q_r <= PW'({1'b0, i_r}) - PW'({1'b0, half_r});
    end else if (cmd.issue) begin
      q_r <= q_r + PW'({1'b0, dil_r});
    end
    if (cmd.issue) begin
      j_d_r <= j_d_r + 4'd1;
    end else if (cmd.tap_start) begin
      j_d_r <= 4'hF;  // first issue wraps to tap 0
    end
    prod_r <= $signed(cfg.coef[j_d_r]) * $signed({1'b0, rdata});
    if (cmd.tap_start) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + dflm_pkg::ACC_W'(prod_r);
    end
  end

  // round half up from Q23.14, then clamp
  assign rnd = acc_r + dflm_pkg::ACC_W'(1 << (dflm_pkg::FRAC_W - 1));
  assign shr = rnd[dflm_pkg::ACC_W-1:dflm_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_last <= last_now;
      if (short_r) begin
        out_filtered <= '0;
        out_flags    <= 2'b10;
      end else if (rnd[dflm_pkg::ACC_W-1]) begin
        out_filtered <= '0;
        out_flags    <= 2'b01;
      end else if (|shr[dflm_pkg::ACC_W-dflm_pkg::FRAC_W-1:16]) begin
        out_filtered <= 16'hFFFF;
        out_flags    <= 2'b01;
      end else begin
        out_filtered <= shr[15:0];
        out_flags    <= 2'b00;
      end
    end
  end

  assign sts.emit      = emit_r;
  assign sts.short_l   = short_r;
  assign sts.more      = end_r && (i_r != p_r);
  assign sts.pipe_busy = rd_v_r | prod_v_r;
  assign sts.out_free  = !out_tvalid || out_tready;
  assign sts.taps      = taps_r;

endmodule
`default_nettype wire

// ----- rtl/dilated_fir_line_mirror.sv -----
// Sequence: an accepted sample first goes to the start state; a filtered
// result then runs the tap loop and waits for the MAC pipeline to drain,
// a short-line result goes straight to the output, and each further result
// of a line-end burst repeats this from the start state. A new sample is
// taken only in the idle state, so the tap loop and output stalls set the pace.
// Reset (synchronous, rst_n low): line position cleared, registers to tap
// count 3, dilation 1, coefficients 0; history contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module dilated_fir_line_mirror (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [15:0]                  in_tdata,   // [15:0] sample
  input  wire logic                         in_tlast,   // line_end
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [15:0]                  out_tdata,  // [15:0] filtered
  output logic      [1:0]                   out_tuser,  // [0] clamped, [1] short_line
  output logic                              out_tlast,  // last_of_line
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [dflm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [dflm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [dflm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  dflm_pkg::cfg_t cfg;
  dflm_pkg::cmd_t cmd;
  dflm_pkg::sts_t sts;

  assign cfg_pready = 1'b1;

  dflm_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg(cfg)
  );

  dflm_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .sts(sts), .cmd(cmd)
  );

  dflm_dp u_dp (
    .clk, .rst_n, .cfg(cfg), .cmd(cmd), .sts(sts),
    .in_sample(in_tdata), .in_end(in_tlast),
    .out_tvalid, .out_tready,
    .out_filtered(out_tdata), .out_flags(out_tuser), .out_last(out_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/dflm_checker.sv -----
// ----------------------------------------------------------------------------
// dflm_checker
// Port-level checks of the dilated FIR block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dflm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 16'd0 && !out_tuser[0])
    else $error("short line result not zero");

  a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 16'd0 || out_tdata == 16'hFFFF)
    else $error("clamped result off the range edge");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dilated_fir_line_mirror dflm_checker u_dflm_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);
`default_nettype wire
